// ===== rtl/core/ttr_pkg.sv =====
// Shared types, constants and mod-12 row functions for the twelve-tone row transform.
package ttr_pkg;

  localparam int NOTES = 12;
  localparam int NIB_W = 4;
  localparam int ROW_W = NOTES * NIB_W;

  typedef logic [ROW_W-1:0] row_t;
  typedef logic [NIB_W-1:0] pc_t;

  localparam logic [2:0] CMD_PRIME  = 3'd0;
  localparam logic [2:0] CMD_INV    = 3'd1;
  localparam logic [2:0] CMD_RETRO  = 3'd2;
  localparam logic [2:0] CMD_RINV   = 3'd3;
  localparam logic [2:0] CMD_MATRIX = 3'd4;

  localparam pc_t         LAST_POS  = pc_t'(NOTES - 1);
  localparam logic [15:0] FULL_SET  = 16'h0FFF;

  typedef enum logic [2:0] {
    KIND_PRIME,
    KIND_INV,
    KIND_RETRO,
    KIND_RINV,
    KIND_MATRIX,
    KIND_ERROR
  } kind_t;

  typedef struct packed {
    kind_t kind;
    row_t  row;
    logic  row_valid;
  } desc_t;

  // reduce a value below 24 + 12 (at most 30 here) to 0..11
  function automatic pc_t mod12(input logic [4:0] v);
    logic [4:0] t;
    t = v;
    if (t >= 5'd24) begin
      t = t - 5'd24;
    end else if (t >= 5'd12) begin
      t = t - 5'd12;
    end
    return t[NIB_W-1:0];
  endfunction

  function automatic pc_t nib(input row_t r, input pc_t idx);
    return r[{idx, 2'b00} +: NIB_W];
  endfunction

  function automatic row_t prime_row(input row_t r, input pc_t n);
    row_t o;
    o = '0;
    for (int i = 0; i < NOTES; i++) begin
      o[i*NIB_W +: NIB_W] = mod12({1'b0, r[i*NIB_W +: NIB_W]} + {1'b0, n});
    end
    return o;
  endfunction

  // expects pitch classes already in 0..11
  function automatic row_t invert_row(input row_t r);
    row_t o;
    pc_t  root;
    pc_t  d;
    o    = '0;
    root = r[NIB_W-1:0];
    for (int i = 0; i < NOTES; i++) begin
      d = mod12({1'b0, root} + 5'd12 - {1'b0, r[i*NIB_W +: NIB_W]});
      o[i*NIB_W +: NIB_W] = mod12({1'b0, d} + {1'b0, root});
    end
    return o;
  endfunction

  function automatic row_t reverse_row(input row_t r);
    row_t o;
    o = '0;
    for (int i = 0; i < NOTES; i++) begin
      o[(NOTES-1-i)*NIB_W +: NIB_W] = r[i*NIB_W +: NIB_W];
    end
    return o;
  endfunction

endpackage

// ===== rtl/core/ttr_front.sv =====
// Front end: row check, transposition and command classification into a descriptor.
module ttr_front
  import ttr_pkg::*;
(
  input  logic [2:0] cmd,
  input  row_t       row_in,
  input  pc_t        shift,
  output desc_t      desc
);

  logic [15:0] seen;
  logic        valid;
  row_t        prime;

  always_comb begin
    seen = '0;
    for (int i = 0; i < NOTES; i++) begin
      seen = seen | (16'd1 << row_in[i*NIB_W +: NIB_W]);
    end
    // any pitch class of 12..15 sets a bit above the full set
    valid = (seen == FULL_SET);
  end

  assign prime = prime_row(row_in, shift);

  always_comb begin
    desc.row_valid = valid;
    desc.row       = prime;
    desc.kind      = KIND_ERROR;
    if (cmd == CMD_PRIME) begin
      desc.kind = KIND_PRIME;
    end else if (valid && (shift <= LAST_POS)) begin
      unique case (cmd)
        CMD_INV:    desc.kind = KIND_INV;
        CMD_RETRO:  desc.kind = KIND_RETRO;
        CMD_RINV:   desc.kind = KIND_RINV;
        CMD_MATRIX: begin
          desc.kind = KIND_MATRIX;
          desc.row  = row_in;
        end
        default:    desc.kind = KIND_ERROR;
      endcase
    end
  end

endmodule

// ===== rtl/core/ttr_queue.sv =====
// Descriptor queue between front and back ends.
module ttr_queue
  import ttr_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  desc_t push_desc,
  input  logic  pop,
  output desc_t head,
  output logic  empty,
  output logic  full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);

  desc_t          entries_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r,  count_nxt;

  assign empty = (count_r == '0);
  assign full  = (count_r == CW'(DEPTH));
  assign head  = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_desc;
    end
  end

endmodule

// ===== rtl/core/ttr_back.sv =====
// Back end: applies the transform and sequences the twelve matrix rows.
module ttr_back
  import ttr_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  desc_t head,
  input  logic  empty,
  output logic  pop,
  output logic  out_valid,
  output row_t  out_row_out,
  output logic  out_error,
  output logic  out_row_valid,
  output logic  out_last
);

  logic  valid_r,     valid_nxt;
  row_t  row_r,       row_nxt;
  logic  error_r,     error_nxt;
  logic  rvalid_r,    rvalid_nxt;
  logic  last_r,      last_nxt;
  logic  mat_act_r,   mat_act_nxt;
  pc_t   mat_idx_r,   mat_idx_nxt;
  row_t  mat_row_r,   mat_row_nxt;
  pc_t   mat_k;

  assign mat_k = mod12({1'b0, nib(mat_row_r, '0)} + 5'd12 - {1'b0, nib(mat_row_r, mat_idx_r)});

  always_comb begin
    pop         = 1'b0;
    valid_nxt   = 1'b0;
    row_nxt     = row_r;
    error_nxt   = error_r;
    rvalid_nxt  = rvalid_r;
    last_nxt    = last_r;
    mat_act_nxt = mat_act_r;
    mat_idx_nxt = mat_idx_r;
    mat_row_nxt = mat_row_r;
    if (mat_act_r) begin
      valid_nxt   = 1'b1;
      row_nxt     = prime_row(mat_row_r, mat_k);
      error_nxt   = 1'b0;
      rvalid_nxt  = 1'b1;
      last_nxt    = (mat_idx_r == LAST_POS);
      mat_idx_nxt = mat_idx_r + 1'b1;
      if (mat_idx_r == LAST_POS) begin
        mat_act_nxt = 1'b0;
      end
    end else if (!empty) begin
      pop        = 1'b1;
      valid_nxt  = 1'b1;
      rvalid_nxt = head.row_valid;
      error_nxt  = 1'b0;
      last_nxt   = 1'b1;
      unique case (head.kind)
        KIND_PRIME:  row_nxt = head.row;
        KIND_INV:    row_nxt = invert_row(head.row);
        KIND_RETRO:  row_nxt = reverse_row(head.row);
        KIND_RINV:   row_nxt = reverse_row(invert_row(head.row));
        KIND_MATRIX: begin
          // first matrix row is the row itself
          row_nxt     = head.row;
          last_nxt    = 1'b0;
          mat_act_nxt = 1'b1;
          mat_idx_nxt = pc_t'(1);
          mat_row_nxt = head.row;
        end
        default: begin
          row_nxt   = '0;
          error_nxt = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= 1'b0;
      mat_act_r <= 1'b0;
      mat_idx_r <= '0;
    end else begin
      valid_r   <= valid_nxt;
      mat_act_r <= mat_act_nxt;
      mat_idx_r <= mat_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_r     <= row_nxt;
    error_r   <= error_nxt;
    rvalid_r  <= rvalid_nxt;
    last_r    <= last_nxt;
    mat_row_r <= mat_row_nxt;
  end

  assign out_valid     = valid_r;
  assign out_row_out   = row_r;
  assign out_error     = error_r;
  assign out_row_valid = rvalid_r;
  assign out_last      = last_r;

endmodule

// ===== rtl/core/twelve_tone_row_transform_top.sv =====
// Top level of the twelve-tone row transform: front end, queue and back end.
// Each item passes the queue, then the output register; it waits while a matrix is in progress.
// One single-result item per cycle, but a matrix item holds the back end for all its 12 rows.
// busy rises when the queue of QUEUE_DEPTH items fills behind a matrix in progress.
// Reset (rst_n low, synchronous) empties the queue and drops any matrix in progress.
// The receiver cannot stall: out_valid marks each result for exactly one cycle.
module twelve_tone_row_transform_top
  import ttr_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_cmd,
  input  logic [47:0] in_row_in,
  input  logic [3:0]  in_shift,
  output logic        out_valid,
  output logic [47:0] out_row_out,
  output logic        out_error,
  output logic        out_row_valid,
  output logic        out_last
);

  desc_t front_desc;
  desc_t head;
  logic  empty;
  logic  full;
  logic  pop;

  ttr_front u_front (
    .cmd    (in_cmd),
    .row_in (in_row_in),
    .shift  (in_shift),
    .desc   (front_desc)
  );

  ttr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (start && !full),
    .push_desc (front_desc),
    .pop       (pop),
    .head      (head),
    .empty     (empty),
    .full      (full)
  );

  ttr_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head          (head),
    .empty         (empty),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_row_out   (out_row_out),
    .out_error     (out_error),
    .out_row_valid (out_row_valid),
    .out_last      (out_last)
  );

  assign busy = full;

endmodule

// ===== rtl/core/ttr_checker.sv =====
// Port-level checks for the twelve-tone row transform, bound to the top level.
module ttr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic [47:0] out_row_out,
  input logic        out_error,
  input logic        out_row_valid,
  input logic        out_last
);

  // matrix rows come out without gaps
  a_matrix_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> out_valid)
    else $error("matrix burst broken");

  a_error_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error |-> out_last && (out_row_out == 48'd0))
    else $error("error item not a single zero result");

  a_invalid_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_row_valid |-> out_last)
    else $error("invalid row gave several results");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result after reset");

endmodule

bind twelve_tone_row_transform_top ttr_checker u_ttr_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_row_out   (out_row_out),
  .out_error     (out_error),
  .out_row_valid (out_row_valid),
  .out_last      (out_last)
);

// ===== dv/tb_twelve_tone_row_transform_top.sv =====
// Self-checking testbench for the twelve-tone row transform top level.
`timescale 1ns / 100ps

module tb_twelve_tone_row_transform_top;
  import ttr_pkg::*;

  localparam int WDOG_LIMIT = 2000;
  localparam int N_RANDOM   = 98;
  localparam int N_DIRECTED = 22;
  localparam row_t ROW_ID   = 48'hBA9876543210;
  localparam row_t ROW_ONES = 48'hFFFFFFFFFFFF;

  typedef struct packed {
    row_t row;
    logic err;
    logic valid;
    logic last;
  } res_t;

  typedef struct packed {
    logic [2:0] cmd;
    row_t       row;
    logic [3:0] shift;
    logic       typed;
    row_t       exp_row;
    logic       exp_err;
    logic       exp_valid;
  } dir_item_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [2:0]  in_cmd;
  logic [47:0] in_row_in;
  logic [3:0]  in_shift;
  logic        out_valid;
  logic [47:0] out_row_out;
  logic        out_error;
  logic        out_row_valid;
  logic        out_last;

  res_t      pending_rows[$];
  dir_item_t dir_tab[N_DIRECTED];
  int        errors;
  int        stall_cnt;
  logic      cur_typed;
  row_t      cur_exp_row;
  logic      cur_exp_err;
  logic      cur_exp_valid;

  twelve_tone_row_transform_top u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_cmd       (in_cmd),
    .in_row_in    (in_row_in),
    .in_shift     (in_shift),
    .out_valid    (out_valid),
    .out_row_out  (out_row_out),
    .out_error    (out_error),
    .out_row_valid(out_row_valid),
    .out_last     (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic row_t transpose(input row_t r, input int n);
    row_t o;
    o = '0;
    for (int i = 0; i < NOTES; i++) begin
      o[i*4 +: 4] = pc_t'((int'(r[i*4 +: 4]) + n) % NOTES);
    end
    return o;
  endfunction

  // pitch classes must already be 0..11
  function automatic row_t mirror(input row_t r);
    row_t o;
    int   root;
    o    = '0;
    root = int'(r[3:0]);
    for (int i = 0; i < NOTES; i++) begin
      o[i*4 +: 4] = pc_t'((2 * root + NOTES - int'(r[i*4 +: 4])) % NOTES);
    end
    return o;
  endfunction

  function automatic row_t retrograde(input row_t r);
    row_t o;
    o = '0;
    for (int i = 0; i < NOTES; i++) begin
      o[(NOTES-1-i)*4 +: 4] = r[i*4 +: 4];
    end
    return o;
  endfunction

  function automatic row_t shuffled_row();
    pc_t  p[NOTES];
    pc_t  t;
    int   j;
    row_t o;
    for (int i = 0; i < NOTES; i++) p[i] = pc_t'(i);
    for (int i = NOTES - 1; i > 0; i--) begin
      j    = $urandom_range(0, i);
      t    = p[i];
      p[i] = p[j];
      p[j] = t;
    end
    o = '0;
    for (int i = 0; i < NOTES; i++) o[i*4 +: 4] = p[i];
    return o;
  endfunction

  task automatic predict_transform(input logic [2:0] cmd, input row_t r, input logic [3:0] s);
    logic [15:0] seen;
    logic        ok;
    int          v;
    int          k;
    row_t        p;
    seen = '0;
    ok   = 1'b1;
    for (int i = 0; i < NOTES; i++) begin
      v = int'(r[i*4 +: 4]);
      if (v >= NOTES || seen[v]) ok = 1'b0;
      else seen[v] = 1'b1;
    end
    p = transpose(r, int'(s));
    if (cmd == CMD_PRIME) begin
      pending_rows.push_back('{p, 1'b0, ok, 1'b1});
    end else if (cmd > CMD_MATRIX || !ok || s >= NOTES) begin
      pending_rows.push_back('{'0, 1'b1, ok, 1'b1});
    end else begin
      case (cmd)
        CMD_INV:   pending_rows.push_back('{mirror(p), 1'b0, 1'b1, 1'b1});
        CMD_RETRO: pending_rows.push_back('{retrograde(p), 1'b0, 1'b1, 1'b1});
        CMD_RINV:  pending_rows.push_back('{retrograde(mirror(p)), 1'b0, 1'b1, 1'b1});
        default: begin
          for (int i = 0; i < NOTES; i++) begin
            k = (int'(r[3:0]) + NOTES - int'(r[i*4 +: 4])) % NOTES;
            pending_rows.push_back('{transpose(r, k), 1'b0, 1'b1, i == NOTES - 1});
          end
        end
      endcase
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    if (rst_n) begin
      if (out_valid) begin
        if (pending_rows.size() == 0) begin
          $display("%0t: unexpected result row %h err %b valid %b last %b", $time,
                   out_row_out, out_error, out_row_valid, out_last);
          errors++;
        end else begin
          want = pending_rows.pop_front();
          if (out_row_out !== want.row) begin
            $display("%0t: row_out expected %h actual %h", $time, want.row, out_row_out);
            errors++;
          end
          if (out_error !== want.err) begin
            $display("%0t: error expected %b actual %b", $time, want.err, out_error);
            errors++;
          end
          if (out_row_valid !== want.valid) begin
            $display("%0t: row_valid expected %b actual %b", $time, want.valid,
                     out_row_valid);
            errors++;
          end
          if (out_last !== want.last) begin
            $display("%0t: last expected %b actual %b", $time, want.last, out_last);
            errors++;
          end
        end
      end
      if (start && !busy) begin
        if (cur_typed) pending_rows.push_back('{cur_exp_row, cur_exp_err, cur_exp_valid, 1'b1});
        else predict_transform(in_cmd, in_row_in, in_shift);
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= WDOG_LIMIT) begin
      $display("FAIL twelve_tone_row_transform_top");
      $finish;
    end
  end

  task automatic idle_burst(input int n);
    for (int k = 0; k < n; k++) begin
      @(negedge clk);
      start     = 1'b0;
      in_cmd    = 3'($urandom);
      in_row_in = row_t'({$urandom, $urandom});
      in_shift  = 4'($urandom);
    end
  endtask

  task automatic send_item(input logic [2:0] cmd, input row_t r, input logic [3:0] s,
                           input logic typed, input row_t er, input logic ee,
                           input logic ev);
    @(negedge clk);
    start         = 1'b1;
    in_cmd        = cmd;
    in_row_in     = r;
    in_shift      = s;
    cur_typed     = typed;
    cur_exp_row   = er;
    cur_exp_err   = ee;
    cur_exp_valid = ev;
    do @(posedge clk); while (busy);
  endtask

  initial begin
    logic [2:0] c;
    row_t       r;
    logic [3:0] s;
    int         pick;
    int         pos;
    errors        = 0;
    stall_cnt     = 0;
    rst_n         = 1'b0;
    start         = 1'b0;
    in_cmd        = '0;
    in_row_in     = '0;
    in_shift      = '0;
    cur_typed     = 1'b0;
    cur_exp_row   = '0;
    cur_exp_err   = 1'b0;
    cur_exp_valid = 1'b0;

    // cmd, row, shift, typed, row_out, error, row_valid
    dir_tab[0]  = '{CMD_PRIME,  ROW_ID,           4'd0,  1'b1, ROW_ID, 1'b0, 1'b1};
    dir_tab[1]  = '{CMD_PRIME,  ROW_ONES,         4'd15, 1'b0, '0, 1'b0, 1'b0};
    dir_tab[2]  = '{CMD_PRIME,  '0,               4'd0,  1'b1, '0, 1'b0, 1'b0};
    dir_tab[3]  = '{CMD_INV,    ROW_ID,           4'd0,  1'b0, '0, 1'b0, 1'b0};
    dir_tab[4]  = '{CMD_INV,    ROW_ID,           4'd11, 1'b0, '0, 1'b0, 1'b0};
    dir_tab[5]  = '{CMD_RETRO,  ROW_ID,           4'd0,  1'b1, 48'h0123456789AB, 1'b0, 1'b1};
    dir_tab[6]  = '{CMD_RINV,   48'h3A05B9184762, 4'd5,  1'b0, '0, 1'b0, 1'b0};
    dir_tab[7]  = '{CMD_MATRIX, ROW_ID,           4'd0,  1'b0, '0, 1'b0, 1'b0};
    dir_tab[8]  = '{CMD_MATRIX, 48'h3A05B9184762, 4'd11, 1'b0, '0, 1'b0, 1'b0};
    dir_tab[9]  = '{CMD_INV,    ROW_ID,           4'd12, 1'b1, '0, 1'b1, 1'b1};
    dir_tab[10] = '{CMD_RETRO,  ROW_ID,           4'd15, 1'b1, '0, 1'b1, 1'b1};
    dir_tab[11] = '{CMD_MATRIX, '0,               4'd0,  1'b1, '0, 1'b1, 1'b0};
    dir_tab[12] = '{CMD_RINV,   ROW_ONES,         4'd0,  1'b1, '0, 1'b1, 1'b0};
    dir_tab[13] = '{3'd5,       ROW_ID,           4'd0,  1'b1, '0, 1'b1, 1'b1};
    dir_tab[14] = '{3'd6,       ROW_ID,           4'd3,  1'b1, '0, 1'b1, 1'b1};
    dir_tab[15] = '{3'd7,       ROW_ONES,         4'd15, 1'b1, '0, 1'b1, 1'b0};
    dir_tab[16] = '{CMD_INV,    48'hAA9876543210, 4'd0,  1'b1, '0, 1'b1, 1'b0};
    dir_tab[17] = '{CMD_RETRO,  48'hCA9876543210, 4'd0,  1'b1, '0, 1'b1, 1'b0};
    dir_tab[18] = '{CMD_PRIME,  48'hCA9876543210, 4'd12, 1'b0, '0, 1'b0, 1'b0};
    dir_tab[19] = '{CMD_MATRIX, 48'h0123456789AB, 4'd3,  1'b0, '0, 1'b0, 1'b0};
    dir_tab[20] = '{CMD_RINV,   ROW_ID,           4'd11, 1'b0, '0, 1'b0, 1'b0};
    dir_tab[21] = '{CMD_MATRIX, ROW_ID,           4'd12, 1'b1, '0, 1'b1, 1'b1};

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_tab[i]) begin
      if ($urandom_range(0, 2) == 0) idle_burst($urandom_range(1, 19));
      send_item(dir_tab[i].cmd, dir_tab[i].row, dir_tab[i].shift, dir_tab[i].typed,
                dir_tab[i].exp_row, dir_tab[i].exp_err, dir_tab[i].exp_valid);
    end

    for (int n = 0; n < N_RANDOM; n++) begin
      pick = $urandom_range(0, 7);
      if (pick < 6) begin
        r = shuffled_row();
        s = 4'($urandom_range(0, 11));
        c = 3'($urandom_range(0, 4));
      end else if (pick == 6) begin
        r = row_t'({$urandom, $urandom});
        s = 4'($urandom);
        c = 3'($urandom);
      end else begin
        // well-formed row with one note overwritten
        r   = shuffled_row();
        pos = $urandom_range(0, NOTES - 1);
        r[pos*4 +: 4] = 4'($urandom);
        s = 4'($urandom);
        c = 3'($urandom_range(0, 4));
      end
      if ((n < 40 || (n >= 60 && n < N_RANDOM - 20)) && $urandom_range(0, 2) == 0)
        idle_burst($urandom_range(1, 19));
      send_item(c, r, s, 1'b0, '0, 1'b0, 1'b0);
    end

    @(negedge clk);
    start = 1'b0;
    while (pending_rows.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("PASS twelve_tone_row_transform_top");
    end else begin
      $display("FAIL twelve_tone_row_transform_top");
    end
    $finish;
  end

endmodule
